// ===== hdl/mksd_pkg.sv =====
// Shared types and constants for the key matrix scanner.
`timescale 1ns / 1ps

package mksd_pkg;

	localparam int NUM_ROWS  = 4;
	localparam int NUM_COLS  = 4;
	localparam int NUM_KEYS  = NUM_ROWS * NUM_COLS;
	localparam int ROW_W     = 2;
	localparam int HIST_W    = 4;
	localparam int CODE_W    = 8;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [HIST_W-1:0] HIST_ALL_LOW  = 4'h0;
	localparam logic [HIST_W-1:0] HIST_ALL_HIGH = 4'hF;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEYMAP_ROW0 = 2'd0,
		REG_KEYMAP_ROW1 = 2'd1,
		REG_KEYMAP_ROW2 = 2'd2,
		REG_KEYMAP_ROW3 = 2'd3
	} reg_idx_t;

	localparam logic [CFG_W-1:0] KEYMAP_ROW0_RST = 32'h2633_3231;
	localparam logic [CFG_W-1:0] KEYMAP_ROW1_RST = 32'h2536_3534;
	localparam logic [CFG_W-1:0] KEYMAP_ROW2_RST = 32'h2839_3837;
	localparam logic [CFG_W-1:0] KEYMAP_ROW3_RST = 32'h270D_1B30;

	// Outcome of one scan tick, handed from the scan core to the emitter.
	typedef struct packed {
		logic [NUM_COLS-1:0]             press;
		logic [NUM_COLS-1:0][CODE_W-1:0] codes;
		logic [NUM_ROWS-1:0]             drive;
	} tick_t;

endpackage

// ===== hdl/mksd_if.sv =====
// Channel interfaces for scan ticks and key results.
`timescale 1ns / 1ps

interface mksd_scan_if;
	logic       valid;
	logic       ready;
	logic [3:0] column_sense;

	modport source (output valid, output column_sense, input ready);
	modport sink   (input valid, input column_sense, output ready);
endinterface

interface mksd_key_if;
	logic       valid;
	logic       ready;
	logic [3:0] row_drive;
	logic       key_valid;
	logic [7:0] key_code;
	logic       last;

	modport source (output valid, output row_drive, output key_valid, output key_code,
		output last, input ready);
	modport sink   (input valid, input row_drive, input key_valid, input key_code,
		input last, output ready);
endinterface

// ===== hdl/mksd_core.sv =====
// Debounce state, key map registers and press detection for one scan tick.
`timescale 1ns / 1ps

module mksd_core
	import mksd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 accept,
	input  logic [NUM_COLS-1:0]  column_sense,
	output tick_t                tick
);

	logic [HIST_W-1:0]   hist_q [NUM_KEYS];
	logic [HIST_W-1:0]   hist_nx [NUM_KEYS];
	logic [NUM_KEYS-1:0] level_q;
	logic [NUM_KEYS-1:0] press_all;
	logic [ROW_W-1:0]    row_q;
	logic [ROW_W-1:0]    row_nx;
	logic [CFG_W-1:0]    keymap_q [NUM_ROWS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keymap_q[0] <= KEYMAP_ROW0_RST;
			keymap_q[1] <= KEYMAP_ROW1_RST;
			keymap_q[2] <= KEYMAP_ROW2_RST;
			keymap_q[3] <= KEYMAP_ROW3_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KEYMAP_ROW0: keymap_q[0] <= cfg_data;
				REG_KEYMAP_ROW1: keymap_q[1] <= cfg_data;
				REG_KEYMAP_ROW2: keymap_q[2] <= cfg_data;
				REG_KEYMAP_ROW3: keymap_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Every key computes its candidate history; only the driven row commits it.
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		localparam logic [ROW_W-1:0] KROW = ROW_W'(k / NUM_COLS);
		localparam int               KCOL = k % NUM_COLS;

		assign hist_nx[k]   = {hist_q[k][HIST_W-2:0], column_sense[KCOL]};
		assign press_all[k] = (hist_nx[k] == HIST_ALL_LOW) && level_q[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hist_q[k]  <= HIST_ALL_HIGH;
				level_q[k] <= 1'b1;
			end else if (accept && (row_q == KROW)) begin
				hist_q[k] <= hist_nx[k];
				if (hist_nx[k] == HIST_ALL_LOW) begin
					level_q[k] <= 1'b0;
				end else if (hist_nx[k] == HIST_ALL_HIGH) begin
					level_q[k] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (accept) begin
			row_q <= row_nx;
		end
	end

	assign row_nx = row_q + ROW_W'(1);

	always_comb begin
		tick.press = press_all[row_q*NUM_COLS +: NUM_COLS];
		for (int c = 0; c < NUM_COLS; c++) begin
			tick.codes[c] = keymap_q[row_q][c*CODE_W +: CODE_W];
		end
		tick.drive = ~(NUM_ROWS'(1) << row_nx);
	end

endmodule

// ===== hdl/mksd_emit.sv =====
// Tick buffer and output register that hand out one key word per cycle while the receiver is ready.
`timescale 1ns / 1ps

module mksd_emit
	import mksd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  tick_t             tick,
	output logic              can_take,
	mksd_key_if.source        key
);

	logic                            buf_valid_q;
	logic [NUM_COLS-1:0]             buf_press_q;
	logic [NUM_COLS-1:0][CODE_W-1:0] buf_codes_q;
	logic [NUM_ROWS-1:0]             buf_drive_q;

	logic                 out_valid_q;
	logic [NUM_ROWS-1:0]  row_drive_q;
	logic                 key_valid_q;
	logic [CODE_W-1:0]    key_code_q;
	logic                 last_q;

	logic                 load_out;
	logic                 take;
	logic [ROW_W-1:0]     sel;
	logic [NUM_COLS-1:0]  remain;
	logic                 is_last;

	assign load_out = !out_valid_q || key.ready;
	assign take     = buf_valid_q && load_out;
	assign remain   = buf_press_q & (buf_press_q - NUM_COLS'(1));
	assign is_last  = (remain == '0);
	assign can_take = !buf_valid_q || (take && is_last);

	// Lowest pending column goes first.
	always_comb begin
		sel = '0;
		for (int c = NUM_COLS - 1; c >= 0; c--) begin
			if (buf_press_q[c]) begin
				sel = ROW_W'(c);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
		end else if (accept) begin
			buf_valid_q <= 1'b1;
		end else if (take && is_last) begin
			buf_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_press_q <= tick.press;
			buf_codes_q <= tick.codes;
			buf_drive_q <= tick.drive;
		end else if (take) begin
			buf_press_q <= remain;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			row_drive_q <= buf_drive_q;
			key_valid_q <= (buf_press_q != '0);
			key_code_q  <= (buf_press_q != '0) ? buf_codes_q[sel] : '0;
			last_q      <= is_last;
		end
	end

	assign key.valid     = out_valid_q;
	assign key.row_drive = row_drive_q;
	assign key.key_valid = key_valid_q;
	assign key.key_code  = key_code_q;
	assign key.last      = last_q;

`ifndef SYNTHESIS
	a_accept_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!buf_valid_q || (take && is_last)))
		else $error("tick accepted over a buffered tick that is not finishing");

	a_buffer_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !is_last) |=> buf_valid_q)
		else $error("tick buffer dropped before its last word");

	a_idle_word_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !key_valid_q) |-> (last_q && (key_code_q == '0)))
		else $error("word without a press must be last with a zero code");

	a_press_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !accept) |=> (buf_press_q == $past(remain)))
		else $error("emitted column not cleared from the tick buffer");
`endif

endmodule

// ===== hdl/matrix_keypad_scan_debounce_top.sv =====
// Top level of the 4x4 key matrix scanner with debouncing.
`timescale 1ns / 1ps

// Each scan word carries the column levels of the row currently driven. The
// levels enter four-sample histories; a key turns pressed after four low
// samples and released after four high ones. A tick yields one key word per
// newly pressed key, lowest column first, or a single word with key_valid low
// when nothing was pressed; every word carries the drive for the next row and
// last marks the final word of the tick. The result path hands out one word
// per cycle while key is ready, so a tick has at most four words. A new scan
// word is taken while the tick buffer is empty or in the cycle it hands out
// its final word, so ticks without presses flow at one per cycle while key is
// ready. Key map registers may be written at any time the block is idle.
module matrix_keypad_scan_debounce_top
	import mksd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	mksd_scan_if.sink            scan,
	mksd_key_if.source           key
);

	logic  accept;
	logic  can_take;
	tick_t tick;

	assign scan.ready = can_take;
	assign accept     = scan.valid && can_take;

	mksd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.column_sense (scan.column_sense),
		.tick         (tick)
	);

	mksd_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.tick     (tick),
		.can_take (can_take),
		.key      (key)
	);

endmodule
